@@ src/piw_pkg.sv @@
// Shared constants and types for the winding-number point-in-polygon block.
// Used by piw_edge and point_in_polygon_winding; depends on nothing else.
package piw_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_COORD_BITS   = 32;

    localparam int MIN_VERTICES = 3;
    localparam int WIND_MAX     = 255;
    localparam int WIND_MIN     = -256;

    localparam logic [8:0] VERTEX_COUNT_RESET = 9'd3;

    localparam logic REG_VERTEX_COUNT = 1'b0;

    localparam logic MODE_VERTEX = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
        logic inc;
        logic dec;
        logic on_edge;
    } edge_res_t;

endpackage

@@ src/piw_edge.sv @@
// Per-edge arithmetic pipeline: vertex offsets, cross and dot products, edge votes.
// Depends on piw_pkg for the edge result struct.
module piw_edge #(
    parameter int COORD_BITS = piw_pkg::DEF_COORD_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic                         in_first,
    input  logic                         in_last,
    input  logic signed [COORD_BITS-1:0] vert_x,
    input  logic signed [COORD_BITS-1:0] vert_y,
    input  logic signed [COORD_BITS-1:0] pt_x,
    input  logic signed [COORD_BITS-1:0] pt_y,
    output piw_pkg::edge_res_t           res
);
    import piw_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic signed [DW-1:0] dx_next, dy_next;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic                 pair_valid_reg, pair_last_reg;

    logic signed [PW-1:0] p_ab_reg, p_ba_reg, p_xx_reg, p_yy_reg;
    logic                 a_low_reg, b_high_reg;
    logic                 prod_valid_reg, prod_last_reg;

    logic signed [XW-1:0] cross_prod, dot;
    logic                 cross_pos, cross_neg, touch;
    edge_res_t            res_reg;

    assign dx_next = DW'(vert_x) - DW'(pt_x);
    assign dy_next = DW'(vert_y) - DW'(pt_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            pair_last_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
        end else begin
            pair_valid_reg <= in_valid && !in_first;
            pair_last_reg  <= in_valid && in_last;
            prod_valid_reg <= pair_valid_reg;
            prod_last_reg  <= pair_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            ax_reg <= bx_reg;
            ay_reg <= by_reg;
            bx_reg <= dx_next;
            by_reg <= dy_next;
        end
        p_ab_reg   <= PW'(ax_reg) * PW'(by_reg);
        p_ba_reg   <= PW'(bx_reg) * PW'(ay_reg);
        p_xx_reg   <= PW'(ax_reg) * PW'(bx_reg);
        p_yy_reg   <= PW'(ay_reg) * PW'(by_reg);
        a_low_reg  <= ay_reg[DW-1] || (ay_reg == '0);
        b_high_reg <= !by_reg[DW-1] && (by_reg != '0);
    end

    assign cross_prod = XW'(p_ab_reg) - XW'(p_ba_reg);
    assign dot        = XW'(p_xx_reg) + XW'(p_yy_reg);
    assign cross_pos  = !cross_prod[XW-1] && (cross_prod != '0);
    assign cross_neg  = cross_prod[XW-1];
    assign touch      = (cross_prod == '0) && (dot[XW-1] || (dot == '0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg.valid   <= prod_valid_reg;
            res_reg.last    <= prod_last_reg;
            res_reg.inc     <= a_low_reg && b_high_reg && cross_pos;
            res_reg.dec     <= !a_low_reg && !b_high_reg && cross_neg;
            res_reg.on_edge <= touch;
        end
    end

    assign res = res_reg;

endmodule

@@ src/point_in_polygon_winding.sv @@
// Top level of the winding-number point-in-polygon block: vertex memories, sequencer,
// winding accumulator, group AND and configuration port. Depends on piw_pkg, piw_edge.
//
//  channel | direction | carries
//  s_      | in        | vertex writes and query points
//  m_      | out       | one result item per query point
//  apb     | in/out    | vertex_count register
//
// A query reads vertices 0..n-1 and vertex 0 again from the single read port of the
// vertex memories, one per cycle, n being the clamped vertex count.
// Reset is synchronous; vertex memories are not cleared. A result waiting on m_tready
// holds back only the next query's ST_FINISH step; vertex writes are still taken.
module point_in_polygon_winding #(
    parameter int MAX_VERTICES = piw_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = piw_pkg::DEF_COORD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // slot[7:0], coord_x[39:8], coord_y[71:40]
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // group_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // point_inside[0], winding[9:1], on_edge[10],
                                   // group_all_inside[11], zero[15:12]
    output logic        m_tlast,   // group_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import piw_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int WW = CW + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH, ST_FINISH} state_t;

    state_t state_reg;

    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic                         rd_valid_reg, rd_first_reg, rd_last_reg;

    logic [8:0]                   vcount_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic                         gend_reg;
    logic [CW-1:0]                k_reg;
    logic signed [WW-1:0]         wn_reg;
    logic                         edge_reg;
    logic                         group_flag_reg;

    logic                         m_tvalid_reg;
    logic [15:0]                  m_tdata_reg;
    logic                         m_tlast_reg;

    logic [31:0]   cnt32, n32, slot32;
    logic [CW-1:0] n_eff;
    logic          s_fire, vert_we, query_go, cfg_we, rd_en, out_free;
    logic [AW-1:0] wr_addr, rd_addr;
    logic signed [31:0] wn32, sat32;
    logic          pt_inside, all_in;
    edge_res_t     res;

    assign cnt32 = {23'b0, vcount_reg};
    always_comb begin
        if (cnt32 < 32'(MIN_VERTICES)) begin
            n32 = 32'(MIN_VERTICES);
        end else if (cnt32 > 32'(MAX_VERTICES)) begin
            n32 = 32'(MAX_VERTICES);
        end else begin
            n32 = cnt32;
        end
    end
    assign n_eff = n32[CW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign slot32   = {24'b0, s_tdata[7:0]};
    assign wr_addr  = slot32[AW-1:0];
    assign vert_we  = s_fire && (s_tuser == MODE_VERTEX) && (slot32 < 32'(MAX_VERTICES));
    assign query_go = s_fire && (s_tuser == MODE_QUERY);
    assign rd_en    = (state_reg == ST_RUN);
    assign rd_addr  = (k_reg == n_eff) ? '0 : k_reg[AW-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (vert_we) begin
            mem_x[wr_addr] <= s_tdata[8 +: COORD_BITS];
            mem_y[wr_addr] <= s_tdata[40 +: COORD_BITS];
        end
        if (rd_en) begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    piw_edge #(
        .COORD_BITS(COORD_BITS)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(rd_valid_reg),
        .in_first(rd_first_reg),
        .in_last (rd_last_reg),
        .vert_x  (rd_x_reg),
        .vert_y  (rd_y_reg),
        .pt_x    (px_reg),
        .pt_y    (py_reg),
        .res     (res)
    );

    assign wn32      = 32'(wn_reg);
    assign pt_inside = (wn_reg != '0);
    assign all_in    = group_flag_reg && pt_inside;
    always_comb begin
        if (wn32 > 32'sd255) begin
            sat32 = 32'(WIND_MAX);
        end else if (wn32 < -32'sd256) begin
            sat32 = 32'(WIND_MIN);
        end else begin
            sat32 = wn32;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            group_flag_reg <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
            rd_first_reg <= rd_en && (k_reg == '0);
            rd_last_reg  <= rd_en && (k_reg == n_eff);
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (query_go) begin
                        k_reg     <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (k_reg == n_eff) begin
                        state_reg <= ST_FLUSH;
                    end else begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                ST_FLUSH: begin
                    if (res.valid && res.last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg   <= 1'b1;
                        m_tdata_reg    <= {4'b0, all_in, edge_reg, sat32[8:0], pt_inside};
                        m_tlast_reg    <= gend_reg;
                        group_flag_reg <= gend_reg ? 1'b1 : all_in;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (query_go) begin
            px_reg   <= s_tdata[8 +: COORD_BITS];
            py_reg   <= s_tdata[40 +: COORD_BITS];
            gend_reg <= s_tlast;
            wn_reg   <= '0;
            edge_reg <= 1'b0;
        end else if (res.valid) begin
            if (res.inc) begin
                wn_reg <= wn_reg + WW'(1);
            end else if (res.dec) begin
                wn_reg <= wn_reg - WW'(1);
            end
            edge_reg <= edge_reg || res.on_edge;
        end
    end

    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VERTEX_COUNT_RESET;
        end else if (cfg_we) begin
            vcount_reg <= pwdata[8:0];
        end
    end

    assign prdata   = (paddr[2] == REG_VERTEX_COUNT) ? {23'b0, vcount_reg} : 32'b0;
    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/piw_checker.sv @@
// Port-level checks for point_in_polygon_winding, attached by the bind below.
// Depends only on the top level's ports.
module piw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Result item changed while stalled.");

    a_inside_matches_winding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[9:1] != 9'd0)))
        else $error("point_inside disagrees with winding.");

    a_group_implies_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[11] || m_tdata[0]))
        else $error("group_all_inside set for a point outside.");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("New item taken right after a query point.");

endmodule

bind point_in_polygon_winding piw_checker u_piw_checker (.*);
